@@ hw/rtl/cas_pkg.sv @@
// Shared types, constants and helper functions of the card UID activation sequencer.
// No dependencies; the controller, datapath and top import this package.
package cas_pkg;

   localparam int UID_MAX = 10;
   localparam int LEVELS  = 3;

   localparam int UCNT_W = $clog2(UID_MAX + 1);
   localparam int UIDX_W = $clog2(UID_MAX);
   localparam int IDX_W  = (UCNT_W > 4) ? UCNT_W : 4;
   localparam int FCNT_W = 3;
   localparam int FIDX_W = 3;
   localparam int LVL_W  = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int FRAME_DEPTH = 5;

   localparam logic [7:0]  REQA_BYTE  = 8'h26;
   localparam logic [7:0]  NVB_ANTI   = 8'h20;
   localparam logic [7:0]  NVB_SELECT = 8'h70;
   localparam logic [2:0]  REQA_BITS  = 3'd7;
   localparam logic [15:0] CRC_PRESET = 16'h6363;
   localparam logic [15:0] CRC_POLY   = 16'h8408;
   localparam int          SAK_CASCADE_BIT = 2;

   localparam logic [FCNT_W-1:0] FC_MAX        = 3'd7;
   localparam logic [FCNT_W-1:0] ATQA_LEN      = 3'd2;
   localparam logic [FCNT_W-1:0] UID_FRAME_LEN = 3'd5;
   localparam logic [FCNT_W-1:0] SAK_LEN       = 3'd3;

   localparam logic [IDX_W-1:0] SEL_IDX_CRC_LO = IDX_W'(7);
   localparam logic [IDX_W-1:0] SEL_IDX_CRC_HI = IDX_W'(8);

   // input commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_FAIL  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_XMIT   = 2'd0;
   localparam logic [1:0] KIND_UID    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // poll end status codes
   localparam logic [2:0] STS_OK        = 3'd0;
   localparam logic [2:0] STS_DISABLED  = 3'd1;
   localparam logic [2:0] STS_NO_ANSWER = 3'd2;
   localparam logic [2:0] STS_BAD_LEN   = 3'd3;
   localparam logic [2:0] STS_BAD_BCC   = 3'd4;
   localparam logic [2:0] STS_LEVELS    = 3'd5;

   localparam logic [CSR_ADDR_W-3:0] REG_READER_ENABLED = '0;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ATQA,
      PH_UID,
      PH_SAK
   } phase_type;

   typedef enum logic [2:0] {
      FSM_LISTEN,
      FSM_CHECK,
      FSM_COPY,
      FSM_DECIDE,
      FSM_EMIT
   } fsm_type;

   typedef enum logic [2:0] {
      JOB_REQA,
      JOB_FAIL,
      JOB_ANTI,
      JOB_SELECT,
      JOB_UID
   } job_type;

   typedef struct packed {
      logic             clear_run;
      logic             take_byte;
      logic             sak_phase;
      logic             copy_en;
      logic [1:0]       copy_idx;
      logic             level_inc;
      logic             start_job;
      logic             emit;
      job_type          job;
      logic [IDX_W-1:0] idx;
      logic [2:0]       fail_code;
   } dp_cmd_type;

   typedef struct packed {
      logic [FCNT_W-1:0] frame_count;
      logic              bcc_ok;
      logic              more;
      logic              level_last;
      logic [UCNT_W-1:0] uid_count;
      logic              out_free;
      logic              reader_enabled;
   } dp_sts_type;

   function automatic logic [7:0] sel_code(input logic [LVL_W-1:0] level);
      logic [7:0] code;
      case (level)
         2'd0:    code = 8'h93;
         2'd1:    code = 8'h95;
         default: code = 8'h97;
      endcase
      return code;
   endfunction

   // one byte of CRC_A, LSB first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/cas_if.sv @@
// Valid/ready channel interfaces for requests and results of the activation sequencer.
// Does not depend on cas_pkg; its field widths are written out directly.
interface cas_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [7:0] rx_byte;
   logic       rx_last;

   modport source (output valid, output cmd, output rx_byte, output rx_last, input ready);
   modport sink (input valid, input cmd, input rx_byte, input rx_last, output ready);
endinterface

interface cas_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic [2:0] bits_last;
   logic       last;
   logic [2:0] status;
   logic [7:0] sak;
   logic [3:0] uid_len;

   modport source (output valid, output kind, output data_byte, output bits_last,
                   output last, output status, output sak, output uid_len, input ready);
   modport sink (input valid, input kind, input data_byte, input bits_last,
                 input last, input status, input sak, input uid_len, output ready);
endinterface

@@ hw/rtl/cas_ctrl.sv @@
// Controller of the activation sequencer: protocol phase, frame checks and result sequencing.
// Depends on cas_pkg and cas_req_if; drives the datapath through dp_cmd_type.
module cas_ctrl (
   input  logic                clock,
   input  logic                reset,
   cas_req_if.sink             req,
   input  cas_pkg::dp_sts_type sts,
   output cas_pkg::dp_cmd_type cmd
);
   import cas_pkg::*;

   fsm_type          state_ff, state_in;
   phase_type        phase_ff, phase_in;
   job_type          job_ff, job_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       copy_idx_ff, copy_idx_in;
   logic [2:0]       fail_ff, fail_in;

   logic    launch;
   job_type launch_job;
   logic [2:0] launch_fail;
   logic    item_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FSM_LISTEN;
         phase_ff    <= PH_IDLE;
         job_ff      <= JOB_FAIL;
         idx_ff      <= '0;
         copy_idx_ff <= '0;
         fail_ff     <= STS_OK;
      end else begin
         state_ff    <= state_in;
         phase_ff    <= phase_in;
         job_ff      <= job_in;
         idx_ff      <= idx_in;
         copy_idx_ff <= copy_idx_in;
         fail_ff     <= fail_in;
      end
   end

   always_comb begin
      case (job_ff)
         JOB_ANTI:   item_last = (idx_ff == IDX_W'(1));
         JOB_SELECT: item_last = (idx_ff == SEL_IDX_CRC_HI);
         JOB_UID:    item_last = (idx_ff == IDX_W'(sts.uid_count));
         default:    item_last = 1'b1;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      job_in      = job_ff;
      idx_in      = idx_ff;
      copy_idx_in = copy_idx_ff;
      fail_in     = fail_ff;
      launch      = 1'b0;
      launch_job  = JOB_FAIL;
      launch_fail = STS_OK;
      req.ready   = 1'b0;

      cmd           = '0;
      cmd.job       = job_ff;
      cmd.idx       = idx_ff;
      cmd.fail_code = fail_ff;
      cmd.copy_idx  = copy_idx_ff;

      case (state_ff)
         FSM_LISTEN: begin
            req.ready = 1'b1;
            if (req.valid) begin
               case (req.cmd)
                  CMD_START: begin
                     cmd.clear_run = 1'b1;
                     launch        = 1'b1;
                     if (sts.reader_enabled) begin
                        launch_job = JOB_REQA;
                     end else begin
                        launch_job  = JOB_FAIL;
                        launch_fail = STS_DISABLED;
                     end
                  end
                  CMD_BYTE: begin
                     if (phase_ff != PH_IDLE) begin
                        cmd.take_byte = 1'b1;
                        cmd.sak_phase = (phase_ff == PH_SAK);
                        if (req.rx_last) begin
                           state_in = FSM_CHECK;
                        end
                     end
                  end
                  CMD_FAIL: begin
                     if (phase_ff != PH_IDLE) begin
                        launch      = 1'b1;
                        launch_fail = STS_NO_ANSWER;
                     end
                  end
                  default: ;
               endcase
            end
         end
         FSM_CHECK: begin
            case (phase_ff)
               PH_ATQA: begin
                  launch = 1'b1;
                  if (sts.frame_count != ATQA_LEN) begin
                     launch_fail = STS_BAD_LEN;
                  end else begin
                     launch_job = JOB_ANTI;
                  end
               end
               PH_UID: begin
                  launch = 1'b1;
                  if (sts.frame_count != UID_FRAME_LEN) begin
                     launch_fail = STS_BAD_LEN;
                  end else if (!sts.bcc_ok) begin
                     launch_fail = STS_BAD_BCC;
                  end else begin
                     launch_job = JOB_SELECT;
                  end
               end
               PH_SAK: begin
                  if (sts.frame_count != SAK_LEN) begin
                     launch      = 1'b1;
                     launch_fail = STS_BAD_LEN;
                  end else begin
                     // skip the cascade tag when another level follows
                     copy_idx_in = {1'b0, sts.more};
                     state_in    = FSM_COPY;
                  end
               end
               default: state_in = FSM_LISTEN;
            endcase
         end
         FSM_COPY: begin
            cmd.copy_en = 1'b1;
            if (copy_idx_ff == 2'd3) begin
               state_in = FSM_DECIDE;
            end else begin
               copy_idx_in = copy_idx_ff + 2'd1;
            end
         end
         FSM_DECIDE: begin
            launch = 1'b1;
            if (!sts.more) begin
               launch_job = JOB_UID;
            end else if (sts.level_last) begin
               launch_fail = STS_LEVELS;
            end else begin
               cmd.level_inc = 1'b1;
               launch_job    = JOB_ANTI;
            end
         end
         FSM_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (item_last) begin
                  state_in = FSM_LISTEN;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: state_in = FSM_LISTEN;
      endcase

      if (launch) begin
         cmd.start_job = 1'b1;
         cmd.job       = launch_job;
         job_in        = launch_job;
         fail_in       = launch_fail;
         idx_in        = '0;
         state_in      = FSM_EMIT;
         case (launch_job)
            JOB_REQA:   phase_in = PH_ATQA;
            JOB_ANTI:   phase_in = PH_UID;
            JOB_SELECT: phase_in = PH_SAK;
            default:    phase_in = PH_IDLE;
         endcase
      end
   end

endmodule

@@ hw/rtl/cas_datapath.sv @@
// Datapath of the activation sequencer: frame and UID stores, CRC_A, config register and
// the result output register. Depends on cas_pkg and cas_rsp_if.
module cas_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  cas_pkg::dp_cmd_type            cmd,
   output cas_pkg::dp_sts_type            sts,
   input  logic [7:0]                     rx_byte,
   cas_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cas_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cas_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cas_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import cas_pkg::*;

   logic              reader_en_ff;
   logic [LVL_W-1:0]  level_ff;
   logic [FCNT_W-1:0] fc_ff;
   logic [7:0]        frame_ff [FRAME_DEPTH];
   logic [7:0]        uid_ff [UID_MAX];
   logic [UCNT_W-1:0] ucnt_ff;
   logic [7:0]        sak_ff;
   logic [15:0]       crc_ff;

   logic       valid_ff;
   logic [1:0] kind_ff;
   logic [7:0] data_ff;
   logic [2:0] bits_ff;
   logic       last_ff;
   logic [2:0] status_ff;
   logic [7:0] sak_out_ff;
   logic [3:0] len_ff;

   logic [1:0] kind_in;
   logic [7:0] data_in;
   logic [2:0] bits_in;
   logic       last_in;
   logic [2:0] status_in;
   logic [7:0] sak_out_in;
   logic [3:0] len_in;

   logic              csr_wr;
   logic              out_free;
   logic [FIDX_W-1:0] rd_addr;
   logic [IDX_W-1:0]  idx_m2;
   logic [7:0]        fs_rd;
   logic [7:0]        uid_rd;
   logic              uid_room;
   logic [2:0]        level_next;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite
                     & (csr_paddr[CSR_ADDR_W-1:2] == REG_READER_ENABLED);
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_READER_ENABLED)
                     ? {{(CSR_DATA_W-1){1'b0}}, reader_en_ff} : '0;

   assign out_free   = !valid_ff || rsp.ready;
   assign uid_room   = (ucnt_ff < UCNT_W'(UID_MAX));
   assign level_next = {1'b0, level_ff} + 3'd1;

   assign sts.frame_count    = fc_ff;
   assign sts.bcc_ok         = ((frame_ff[0] ^ frame_ff[1] ^ frame_ff[2] ^ frame_ff[3])
                                == frame_ff[4]);
   assign sts.more           = sak_ff[SAK_CASCADE_BIT];
   assign sts.level_last     = (level_next >= 3'(LEVELS));
   assign sts.uid_count      = ucnt_ff;
   assign sts.out_free       = out_free;
   assign sts.reader_enabled = reader_en_ff;

   // one read port on the frame store, shared by the UID copy and the select frame
   assign idx_m2  = cmd.idx - IDX_W'(2);
   assign rd_addr = cmd.copy_en ? {1'b0, cmd.copy_idx} : idx_m2[FIDX_W-1:0];
   assign fs_rd   = (rd_addr < FIDX_W'(FRAME_DEPTH)) ? frame_ff[rd_addr] : 8'h00;
   assign uid_rd  = (cmd.idx < IDX_W'(UID_MAX)) ? uid_ff[cmd.idx[UIDX_W-1:0]] : 8'h00;

   always_comb begin
      kind_in    = KIND_XMIT;
      data_in    = 8'h00;
      bits_in    = 3'd0;
      last_in    = 1'b0;
      status_in  = STS_OK;
      sak_out_in = 8'h00;
      len_in     = 4'd0;
      case (cmd.job)
         JOB_REQA: begin
            data_in = REQA_BYTE;
            bits_in = REQA_BITS;
            last_in = 1'b1;
         end
         JOB_FAIL: begin
            kind_in   = KIND_STATUS;
            last_in   = 1'b1;
            status_in = cmd.fail_code;
         end
         JOB_ANTI: begin
            if (cmd.idx == '0) begin
               data_in = sel_code(level_ff);
            end else begin
               data_in = NVB_ANTI;
               last_in = 1'b1;
            end
         end
         JOB_SELECT: begin
            if (cmd.idx == '0) begin
               data_in = sel_code(level_ff);
            end else if (cmd.idx == IDX_W'(1)) begin
               data_in = NVB_SELECT;
            end else if (cmd.idx == SEL_IDX_CRC_LO) begin
               data_in = crc_ff[7:0];
            end else if (cmd.idx == SEL_IDX_CRC_HI) begin
               data_in = crc_ff[15:8];
               last_in = 1'b1;
            end else begin
               data_in = fs_rd;
            end
         end
         JOB_UID: begin
            if (cmd.idx < IDX_W'(ucnt_ff)) begin
               kind_in = KIND_UID;
               data_in = uid_rd;
            end else begin
               kind_in    = KIND_STATUS;
               last_in    = 1'b1;
               sak_out_in = sak_ff;
               len_in     = 4'(ucnt_ff);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reader_en_ff <= 1'b0;
         level_ff     <= '0;
         fc_ff        <= '0;
         ucnt_ff      <= '0;
         sak_ff       <= 8'h00;
         crc_ff       <= CRC_PRESET;
         valid_ff     <= 1'b0;
      end else begin
         if (csr_wr) begin
            reader_en_ff <= csr_pwdata[0];
         end

         if (cmd.take_byte) begin
            if (fc_ff != FC_MAX) begin
               fc_ff <= fc_ff + 3'd1;
            end
            if (cmd.sak_phase && fc_ff == '0) begin
               sak_ff <= rx_byte;
            end
         end

         if (cmd.copy_en && uid_room) begin
            ucnt_ff <= ucnt_ff + UCNT_W'(1);
         end

         if (cmd.level_inc) begin
            level_ff <= level_ff + LVL_W'(1);
         end

         if (cmd.clear_run) begin
            level_ff <= '0;
            ucnt_ff  <= '0;
            fc_ff    <= '0;
         end

         if (cmd.start_job) begin
            fc_ff  <= '0;
            crc_ff <= CRC_PRESET;
            if (cmd.job == JOB_FAIL) begin
               ucnt_ff <= '0;
            end
         end

         // fold each select byte ahead of the CRC bytes into CRC_A
         if (cmd.emit && cmd.job == JOB_SELECT && cmd.idx < SEL_IDX_CRC_LO) begin
            crc_ff <= crc_byte(crc_ff, data_in);
         end

         if (cmd.emit) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   // payload stores, no reset
   always_ff @(posedge clock) begin
      if (cmd.take_byte && !cmd.sak_phase && fc_ff < FCNT_W'(FRAME_DEPTH)) begin
         frame_ff[fc_ff] <= rx_byte;
      end
      if (cmd.copy_en && uid_room) begin
         uid_ff[ucnt_ff[UIDX_W-1:0]] <= fs_rd;
      end
      if (cmd.emit) begin
         kind_ff    <= kind_in;
         data_ff    <= data_in;
         bits_ff    <= bits_in;
         last_ff    <= last_in;
         status_ff  <= status_in;
         sak_out_ff <= sak_out_in;
         len_ff     <= len_in;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.kind      = kind_ff;
   assign rsp.data_byte = data_ff;
   assign rsp.bits_last = bits_ff;
   assign rsp.last      = last_ff;
   assign rsp.status    = status_ff;
   assign rsp.sak       = sak_out_ff;
   assign rsp.uid_len   = len_ff;

endmodule

@@ hw/rtl/card_uid_activation_sequencer_top.sv @@
// A received byte that does not end a frame is taken; a start launches its job, whose first
// result is loaded in the emit state. A frame end passes the check state (after SAK also the
// UID copy and level decision states) before its first result is loaded. Throughput: results
// leave at one per cycle from the output register while the receiver is ready; a select frame
// is nine transfers, a UID run up to UID_MAX plus one. Input is taken only while no result
// is being sequenced. Reset is synchronous and active high: phase idle, reader disabled.
module card_uid_activation_sequencer_top (
   input  logic                           clock,
   input  logic                           reset,
   cas_req_if.sink                        req_chan,
   cas_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cas_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cas_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cas_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import cas_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   cas_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .sts   (dp_sts),
      .cmd   (dp_cmd)
   );

   cas_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .sts         (dp_sts),
      .rx_byte     (req_chan.rx_byte),
      .rsp         (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

`ifndef NO_ASSERTIONS
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |-> dp_sts.out_free)
      else $error("result loaded while output register still full");

   a_no_accept_while_emitting: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> !dp_cmd.emit)
      else $error("input accepted while results are sequenced");

   a_status_only_on_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind != KIND_STATUS)
      |-> (rsp_chan.status == STS_OK && rsp_chan.sak == 8'h00 && rsp_chan.uid_len == 4'd0))
      else $error("status fields set on a byte result");

   a_fail_clears_uid: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == KIND_STATUS && rsp_chan.status != STS_OK)
      |-> (rsp_chan.uid_len == 4'd0 && rsp_chan.sak == 8'h00 && rsp_chan.last))
      else $error("failure status carries UID length or SAK");
`endif

endmodule
